// ===== rtl/ecwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecwq_pkg
// Shared widths, register map, reset values and structs for the eye-closure
// window qualifier.
// ----------------------------------------------------------------------------
package ecwq_pkg;

  // Field widths
  localparam int unsigned RunLimitW    = 8;
  localparam int unsigned ClosedLimitW = 7;
  localparam int unsigned HoldW        = 8;
  localparam int unsigned RunW         = 16;
  localparam int unsigned WinCountW    = 7;

  // Configuration bus
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register reset values
  localparam logic [RunLimitW-1:0]    RunLimitRst    = 8'd15;
  localparam logic [ClosedLimitW-1:0] ClosedLimitRst = 7'd10;
  localparam logic [HoldW-1:0]        HoldFramesRst  = 8'd60;

  // Saturation value of the run counter
  localparam logic [RunW-1:0] RunMax = '1;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_RUN_LIMIT    = 2'd0,
    REG_CLOSED_LIMIT = 2'd1,
    REG_HOLD_FRAMES  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [RunLimitW-1:0]    run_limit;
    logic [ClosedLimitW-1:0] closed_limit;
    logic [HoldW-1:0]        hold_frames;
  } cfg_t;

  typedef struct packed {
    logic                 drowsy;
    logic [RunW-1:0]      closed_run;
    logic [WinCountW-1:0] closed_in_window;
    logic                 window_full;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/ecwq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecwq_in_if
// Per-frame flag channel: valid/ready handshake with face and eyes flags.
// ----------------------------------------------------------------------------
interface ecwq_in_if;
  logic valid;
  logic ready;
  logic face_found;
  logic eyes_found;

  modport source (output valid, output face_found, output eyes_found, input ready);
  modport sink   (input valid, input face_found, input eyes_found, output ready);
endinterface
`default_nettype wire

// ===== rtl/ecwq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecwq_out_if
// Per-frame result channel: valid/ready handshake with the drowsy status.
// ----------------------------------------------------------------------------
interface ecwq_out_if;
  logic                            valid;
  logic                            ready;
  logic                            drowsy;
  logic [ecwq_pkg::RunW-1:0]       closed_run;
  logic [ecwq_pkg::WinCountW-1:0]  closed_in_window;
  logic                            window_full;

  modport source (output valid, output drowsy, output closed_run,
                  output closed_in_window, output window_full, input ready);
  modport sink   (input valid, input drowsy, input closed_run,
                  input closed_in_window, input window_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/ecwq_window_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecwq_window_core
// Window, run and hold state; computes one frame's update in a single step.
// ----------------------------------------------------------------------------
module ecwq_window_core #(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             face_i,
  input  wire logic             eyes_i,
  input  wire ecwq_pkg::cfg_t   cfg_i,
  output ecwq_pkg::result_t     result_o
);

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);
  localparam logic [CntW-1:0] WinLen = CntW'(WINDOW_LEN);

  logic [WINDOW_LEN-1:0]        window_q, window_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic [CntW-1:0]              closed_q, closed_d;
  logic [ecwq_pkg::RunW-1:0]    run_q, run_d;
  logic [ecwq_pkg::HoldW-1:0]   hold_q, hold_d;
  logic                         drowsy_d;
  logic                         closed;
  logic                         oldest;
  logic                         full;
  logic                         trig;

  // Oldest entry sits at the far end of the shift line once the window is full
  assign closed = face_i & ~eyes_i;
  assign oldest = window_q[WINDOW_LEN-1];

  // Run counter: count closed frames, saturate, clear on any other frame
  always_comb begin
    if (closed) begin
      run_d = (run_q == ecwq_pkg::RunMax) ? run_q : run_q + 1'b1;
    end else begin
      run_d = '0;
    end
  end

  // Window: shift in on a face frame, empty on a frame without a face
  always_comb begin
    window_d = window_q;
    if (face_i) begin
      window_d = {window_q[WINDOW_LEN-2:0], closed};
      if (fill_q == WinLen) begin
        fill_d   = fill_q;
        closed_d = closed_q - CntW'(oldest) + CntW'(closed);
      end else begin
        fill_d   = fill_q + 1'b1;
        closed_d = closed_q + CntW'(closed);
      end
    end else begin
      fill_d   = '0;
      closed_d = '0;
    end
  end

  // Trigger and hold
  assign full = (fill_d == WinLen);
  assign trig = (full && (ecwq_pkg::WinCountW'(closed_d) >= cfg_i.closed_limit))
              || (run_d >= ecwq_pkg::RunW'(cfg_i.run_limit));

  always_comb begin
    if (trig) begin
      drowsy_d = 1'b1;
      hold_d   = cfg_i.hold_frames;
    end else if (hold_q != '0) begin
      hold_d   = hold_q - 1'b1;
      drowsy_d = (hold_q != ecwq_pkg::HoldW'(1));
    end else begin
      hold_d   = '0;
      drowsy_d = 1'b0;
    end
  end

  // Result of this frame
  always_comb begin
    result_o.drowsy           = drowsy_d;
    result_o.closed_run       = run_d;
    result_o.closed_in_window = full ? ecwq_pkg::WinCountW'(closed_d) : '0;
    result_o.window_full      = full;
  end

  // Advance state on each frame step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      closed_q <= '0;
      run_q    <= '0;
      hold_q   <= '0;
    end else if (step_i) begin
      fill_q   <= fill_d;
      closed_q <= closed_d;
      run_q    <= run_d;
      hold_q   <= hold_d;
    end
  end

  // Window bits need no reset; the fill count guards them
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      window_q <= window_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/eye_closure_window_qualifier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted frame moves from the input register into the result register.
// Throughput: one frame per cycle while the receiver takes each result;
// the window, run and hold counters update in one registered step per
// frame. While a result waits, one more frame is taken into the input
// register; the input stalls after that.
// Reset (rst_ni low, asynchronous) empties the window, clears the counters
// and loads run_limit 15, closed_limit 10, hold_frames 60.
// ----------------------------------------------------------------------------
// eye_closure_window_qualifier_top
// Sliding-window eye-closure qualifier with an APB-style register port.
// ----------------------------------------------------------------------------
module eye_closure_window_qualifier_top #(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ecwq_in_if.sink                            in_i,
  ecwq_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ecwq_pkg::AddrW-1:0]    paddr,
  input  wire logic [ecwq_pkg::DataW-1:0]    pwdata,
  output logic [ecwq_pkg::DataW-1:0]         prdata,
  output logic                               pready
);

  ecwq_pkg::cfg_t     cfg_q;
  ecwq_pkg::result_t  step_result;
  ecwq_pkg::result_t  res_q;
  ecwq_pkg::reg_idx_e reg_idx;
  logic               wr_en;
  logic               in_valid_q;
  logic               face_q;
  logic               eyes_q;
  logic               out_valid_q;
  logic               out_free;
  logic               step;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = ecwq_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_limit    <= ecwq_pkg::RunLimitRst;
      cfg_q.closed_limit <= ecwq_pkg::ClosedLimitRst;
      cfg_q.hold_frames  <= ecwq_pkg::HoldFramesRst;
    end else if (wr_en) begin
      case (reg_idx)
        ecwq_pkg::REG_RUN_LIMIT:    cfg_q.run_limit    <= pwdata[ecwq_pkg::RunLimitW-1:0];
        ecwq_pkg::REG_CLOSED_LIMIT: cfg_q.closed_limit <= pwdata[ecwq_pkg::ClosedLimitW-1:0];
        ecwq_pkg::REG_HOLD_FRAMES:  cfg_q.hold_frames  <= pwdata[ecwq_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ecwq_pkg::REG_RUN_LIMIT:    prdata = ecwq_pkg::DataW'(cfg_q.run_limit);
      ecwq_pkg::REG_CLOSED_LIMIT: prdata = ecwq_pkg::DataW'(cfg_q.closed_limit);
      ecwq_pkg::REG_HOLD_FRAMES:  prdata = ecwq_pkg::DataW'(cfg_q.hold_frames);
      default:                    prdata = '0;
    endcase
  end

  // Handshake: input stage advances when the result stage is free
  assign out_free   = ~out_valid_q | out_o.ready;
  assign step       = in_valid_q & out_free;
  assign in_i.ready = ~in_valid_q | out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      face_q <= in_i.face_found;
      eyes_q <= in_i.eyes_found;
    end
  end

  // Per-frame update
  ecwq_window_core #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .face_i   (face_q),
    .eyes_i   (eyes_q),
    .cfg_i    (cfg_q),
    .result_o (step_result)
  );

  // Result register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= step_result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.drowsy           = res_q.drowsy;
  assign out_o.closed_run       = res_q.closed_run;
  assign out_o.closed_in_window = res_q.closed_in_window;
  assign out_o.window_full      = res_q.window_full;

endmodule
`default_nettype wire

// ===== test/eye_closure_window_qualifier_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eye_closure_window_qualifier_top_test
// Drives frames of face/eyes flags through the qualifier under random gaps and
// stalls and checks every status transfer against an in-bench model of the
// sliding window, run counter and drowsy hold. Phases cover the limit
// registers at their extremes, a spare register address and a closed run well
// past the run limit.
// ----------------------------------------------------------------------------
module eye_closure_window_qualifier_top_test;

  localparam int unsigned WinLen      = 20;
  localparam int unsigned LongStall   = 120;
  localparam int unsigned MaxPrinted  = 100;
  localparam int unsigned LongRunLen  = 280;
  localparam int unsigned BufDepth    = 8192;
  localparam longint unsigned LimitNs = 64'd5_000_000;
  // Address slot past the last register; writes there must be dropped
  localparam logic [1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic face;
    logic eyes;
  } frame_t;

  logic clk_i;
  logic rst_ni = 1'b1;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ecwq_pkg::AddrW-1:0] paddr;
  logic [ecwq_pkg::DataW-1:0] pwdata;
  logic [ecwq_pkg::DataW-1:0] prdata;
  logic                       pready;

  ecwq_in_if  frame_if ();
  ecwq_out_if status_if ();

  eye_closure_window_qualifier_top #(
    .WINDOW_LEN(WinLen)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (frame_if),
    .out_o  (status_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Frames waiting to be offered and statuses waiting to come back
  frame_t            frame_buf[BufDepth];
  int unsigned       frame_wr = 0;
  int unsigned       frame_rd = 0;
  ecwq_pkg::result_t status_buf[BufDepth];
  int unsigned       status_wr = 0;
  int unsigned       status_rd = 0;

  // Idling bounds, changed between phases only
  int unsigned send_gap_max   = 4;
  int unsigned recv_stall_max = 4;

  int unsigned mismatch_count = 0;

  // Model state of the qualifier
  ecwq_pkg::cfg_t limits = '{run_limit: ecwq_pkg::RunLimitRst,
                             closed_limit: ecwq_pkg::ClosedLimitRst,
                             hold_frames: ecwq_pkg::HoldFramesRst};
  logic [WinLen-1:0] closed_ring = '0;
  int unsigned ring_ptr   = 0;
  int unsigned fill_cnt   = 0;
  int unsigned closed_cnt = 0;
  logic [ecwq_pkg::RunW-1:0]  run_cnt   = '0;
  logic [ecwq_pkg::HoldW-1:0] hold_cnt  = '0;
  logic                       drowsy_st = 1'b0;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("MISMATCH: %s", msg);
  endtask

  // Advance the model by one frame and queue the status it yields
  task automatic predict_status(input frame_t f);
    logic              closed;
    logic              full;
    logic              trig;
    ecwq_pkg::result_t r;
    closed = f.face && !f.eyes;
    if (closed) begin
      if (run_cnt != ecwq_pkg::RunMax) run_cnt++;
    end else begin
      run_cnt = '0;
    end
    if (f.face) begin
      // drop the oldest entry once the window is full
      if (fill_cnt == WinLen) closed_cnt -= closed_ring[ring_ptr];
      else fill_cnt++;
      closed_ring[ring_ptr] = closed;
      closed_cnt += closed;
      ring_ptr = (ring_ptr == WinLen - 1) ? 0 : ring_ptr + 1;
    end else begin
      fill_cnt   = 0;
      closed_cnt = 0;
      ring_ptr   = 0;
    end
    full = (fill_cnt == WinLen);
    trig = (full && closed_cnt >= limits.closed_limit) || (run_cnt >= limits.run_limit);
    if (trig) begin
      drowsy_st = 1'b1;
      hold_cnt  = limits.hold_frames;
    end else if (hold_cnt != '0) begin
      hold_cnt--;
      drowsy_st = (hold_cnt != '0);
    end else begin
      drowsy_st = 1'b0;
    end
    r.drowsy           = drowsy_st;
    r.closed_run       = run_cnt;
    r.closed_in_window = full ? ecwq_pkg::WinCountW'(closed_cnt) : '0;
    r.window_full      = full;
    status_buf[status_wr] = r;
    status_wr++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Frame driver: offer queued frames, idle a random number of cycles after each
  frame_t      offered;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_if.valid      <= 1'b0;
      frame_if.face_found <= 1'b0;
      frame_if.eyes_found <= 1'b0;
      gap_left = 0;
    end else begin
      if (frame_if.valid && frame_if.ready) predict_status(offered);
      if (!frame_if.valid || frame_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          frame_if.valid <= 1'b0;
        end else if (frame_rd != frame_wr) begin
          offered = frame_buf[frame_rd];
          frame_rd++;
          frame_if.valid      <= 1'b1;
          frame_if.face_found <= offered.face;
          frame_if.eyes_found <= offered.eyes;
          gap_left = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: check each transfer, then stall a random number of cycles
  int unsigned       stall_left;
  int unsigned       statuses_seen;
  ecwq_pkg::result_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_if.ready <= 1'b0;
      stall_left    = 0;
      statuses_seen = 0;
    end else begin
      if (status_if.valid && status_if.ready) begin
        if (status_rd == status_wr) begin
          note_mismatch($sformatf("status %0d arrived with no frame pending", statuses_seen));
        end else begin
          want = status_buf[status_rd];
          status_rd++;
          if (status_if.drowsy !== want.drowsy)
            note_mismatch($sformatf("status %0d drowsy %b, want %b", statuses_seen,
                                    status_if.drowsy, want.drowsy));
          if (status_if.closed_run !== want.closed_run)
            note_mismatch($sformatf("status %0d closed_run %0d, want %0d", statuses_seen,
                                    status_if.closed_run, want.closed_run));
          if (status_if.closed_in_window !== want.closed_in_window)
            note_mismatch($sformatf("status %0d closed_in_window %0d, want %0d",
                                    statuses_seen, status_if.closed_in_window,
                                    want.closed_in_window));
          if (status_if.window_full !== want.window_full)
            note_mismatch($sformatf("status %0d window_full %b, want %b", statuses_seen,
                                    status_if.window_full, want.window_full));
        end
        statuses_seen++;
        // hold off for a long stretch twice so the block backs up into its input
        if (statuses_seen == 400 || statuses_seen == 1200) stall_left = LongStall;
        else stall_left = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      status_if.ready <= (stall_left == 0);
    end
  end

  // Register access: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [ecwq_pkg::DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ecwq_pkg::REG_RUN_LIMIT:
        limits.run_limit    = data[ecwq_pkg::RunLimitW-1:0];
      ecwq_pkg::REG_CLOSED_LIMIT:
        limits.closed_limit = data[ecwq_pkg::ClosedLimitW-1:0];
      ecwq_pkg::REG_HOLD_FRAMES:
        limits.hold_frames  = data[ecwq_pkg::HoldW-1:0];
      default: ;
    endcase
  endtask

  task automatic read_check(input logic [1:0] idx,
                            input logic [ecwq_pkg::DataW-1:0] exp_val);
    logic [ecwq_pkg::DataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    // prdata is stable through the access cycle
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== exp_val)
      note_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got, exp_val));
  endtask

  task automatic check_limits();
    read_check(ecwq_pkg::REG_RUN_LIMIT,    ecwq_pkg::DataW'(limits.run_limit));
    read_check(ecwq_pkg::REG_CLOSED_LIMIT, ecwq_pkg::DataW'(limits.closed_limit));
    read_check(ecwq_pkg::REG_HOLD_FRAMES,  ecwq_pkg::DataW'(limits.hold_frames));
  endtask

  // Write all three limits with junk in the unused upper bits
  task automatic set_limits(input logic [ecwq_pkg::RunLimitW-1:0]    run,
                            input logic [ecwq_pkg::ClosedLimitW-1:0] cl,
                            input logic [ecwq_pkg::HoldW-1:0]        hold);
    write_reg(ecwq_pkg::REG_RUN_LIMIT,
              ($urandom & 32'hFFFF_FF00) | ecwq_pkg::DataW'(run));
    write_reg(ecwq_pkg::REG_CLOSED_LIMIT,
              ($urandom & 32'hFFFF_FF80) | ecwq_pkg::DataW'(cl));
    write_reg(ecwq_pkg::REG_HOLD_FRAMES,
              ($urandom & 32'hFFFF_FF00) | ecwq_pkg::DataW'(hold));
    check_limits();
  endtask

  // Wait until every frame has gone in and every status has come back
  task automatic drain_frames();
    while (frame_rd != frame_wr || frame_if.valid || status_rd != status_wr)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_frames(input logic face, input logic eyes, input int unsigned n);
    frame_t f;
    f.face = face;
    f.eyes = eyes;
    repeat (n) begin
      frame_buf[frame_wr] = f;
      frame_wr++;
    end
  endtask

  // Random frames in bursts: long face-present stretches with a per-burst
  // closed rate, short no-face bursts and sparse dropouts
  task automatic queue_random_frames(input int unsigned n);
    int unsigned added;
    int unsigned len;
    int unsigned closed_pct;
    int unsigned noface_pct;
    frame_t      f;
    added = 0;
    while (added < n) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0:       closed_pct = 0;
        1:       closed_pct = 100;
        2:       closed_pct = 50;
        3:       closed_pct = 80;
        default: closed_pct = $urandom_range(0, 100);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        noface_pct = 100;
        len = $urandom_range(1, 3);
      end else begin
        noface_pct = ($urandom_range(0, 2) == 0) ? 4 : 0;
      end
      repeat (len) begin
        f.face = ($urandom_range(0, 99) >= noface_pct);
        f.eyes = f.face ? ($urandom_range(0, 99) >= closed_pct) : 1'($urandom_range(0, 1));
        frame_buf[frame_wr] = f;
        frame_wr++;
      end
      added += len;
    end
  endtask

  // Stimulus
  initial begin
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, then no-face frames, a window filled with open frames
    // and a short closed run
    check_limits();
    add_frames(1'b0, 1'b0, 1);
    add_frames(1'b0, 1'b1, 1);
    add_frames(1'b1, 1'b1, WinLen);
    add_frames(1'b1, 1'b0, 3);
    drain_frames();

    // Reset limits under full idling
    queue_random_frames(200);
    drain_frames();

    // Lowest legal limits, sender never idles
    send_gap_max = 0;
    set_limits(8'd1, 7'd1, 8'd1);
    queue_random_frames(200);
    drain_frames();

    // Zero limits: trigger on every frame, hold of zero; no idling at all
    recv_stall_max = 0;
    set_limits(8'd0, 7'd0, 8'd0);
    queue_random_frames(120);
    drain_frames();

    // Highest run and hold limits; closed limit beyond the window never triggers there
    send_gap_max   = 4;
    recv_stall_max = 4;
    set_limits(8'd255, 7'd64, 8'd255);
    queue_random_frames(200);
    drain_frames();

    // Closed limit equal to the window length, hold of zero; receiver never stalls
    recv_stall_max = 0;
    set_limits(8'd5, 7'(WinLen), 8'd0);
    queue_random_frames(200);
    drain_frames();

    // Top of the closed limit field; writes to the spare slot leave the limits alone
    recv_stall_max = 4;
    set_limits(8'd40, 7'd127, 8'd3);
    write_reg(RegSpare, $urandom);
    check_limits();
    queue_random_frames(200);
    drain_frames();

    // Closed run well past the highest run limit, then release
    send_gap_max   = 0;
    recv_stall_max = 0;
    set_limits(8'd255, 7'd64, 8'd2);
    add_frames(1'b1, 1'b0, LongRunLen);
    add_frames(1'b1, 1'b1, 3);
    add_frames(1'b0, 1'b1, 2);
    drain_frames();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("eye_closure_window_qualifier_top_test OK");
    end else begin
      $display("eye_closure_window_qualifier_top_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitNs);
    $display("eye_closure_window_qualifier_top_test NOT OK");
    $finish;
  end

endmodule
